// ----- design/tds_pkg.sv -----
// package for the triangle depth sort unit
// types and constants shared by the front end, key queue and sorter; no dependencies
`default_nettype none
package tds_pkg;

  localparam int unsigned IdxW   = 6;
  localparam int unsigned CoordW = 32;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned AccW   = 67;

  localparam logic [1:0] RegCoeffX = 2'd0;
  localparam logic [1:0] RegCoeffY = 2'd1;
  localparam logic [1:0] RegCoeffZ = 2'd2;
  localparam logic [1:0] RegOffset = 2'd3;

  localparam logic signed [KeyW-1:0] KeyMax = {1'b0, {(KeyW-1){1'b1}}};
  localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};

  typedef struct packed {
    logic [IdxW-1:0]        idx;
    logic signed [KeyW-1:0] key;
    logic                   last;
  } key_item_t;

  typedef enum logic [2:0] {
    SRT_LOAD,
    SRT_SCAN,
    SRT_EMIT,
    SRT_NEXT
  } srt_state_t;

  function automatic logic signed [KeyW-1:0] sat_key(input logic signed [AccW-1:0] v);
    logic signed [KeyW-1:0] r;
    begin
      if (v > $signed({{(AccW-KeyW){KeyMax[KeyW-1]}}, KeyMax})) r = KeyMax;
      else if (v < $signed({{(AccW-KeyW){KeyMin[KeyW-1]}}, KeyMin})) r = KeyMin;
      else r = v[KeyW-1:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/tds_front.sv -----
// front end: accepts triangles and computes their depth keys in a pipeline
// depends on tds_pkg
`default_nettype none
module tds_front
  import tds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [IdxW-1:0]          in_idx,
  input  wire logic [9*CoordW-1:0]      in_pos,
  input  wire logic                     in_last,
  input  wire logic signed [CoordW-1:0] coeff_x,
  input  wire logic signed [CoordW-1:0] coeff_y,
  input  wire logic signed [CoordW-1:0] coeff_z,
  input  wire logic signed [CoordW-1:0] offset,
  output logic                          key_valid,
  output key_item_t                     key_item,
  input  wire logic                     q_space
);

  // stage 1: nine products, stage 2: three depths, stage 3: max
  logic                         v1, v2;
  logic [IdxW-1:0]              idx1, idx2;
  logic                         last1, last2;
  logic signed [ProdW-1:0]      prod [9];
  logic signed [KeyW-1:0]       dep [3];
  logic signed [CoordW-1:0]     cf [3];
  logic signed [AccW-1:0]       offs;
  logic signed [KeyW-1:0]       kmax;
  logic                         adv;

  assign cf[0] = coeff_x;
  assign cf[1] = coeff_y;
  assign cf[2] = coeff_z;
  assign offs  = {{(AccW-CoordW-16){offset[CoordW-1]}}, offset, 16'h0000};

  // q_space guarantees room for every item in flight
  assign adv      = q_space;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      key_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      key_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1  <= in_idx;
      last1 <= in_last;
      for (int i = 0; i < 9; i++) begin
        prod[i] <= $signed(in_pos[i*CoordW +: CoordW]) * cf[i%3];
      end
      idx2  <= idx1;
      last2 <= last1;
      for (int v = 0; v < 3; v++) begin
        dep[v] <= sat_key({{(AccW-ProdW){prod[3*v][ProdW-1]}}, prod[3*v]}
                        + {{(AccW-ProdW){prod[3*v+1][ProdW-1]}}, prod[3*v+1]}
                        + {{(AccW-ProdW){prod[3*v+2][ProdW-1]}}, prod[3*v+2]}
                        + offs);
      end
      key_item.idx  <= idx2;
      key_item.key  <= kmax;
      key_item.last <= last2;
    end
  end

  always_comb begin
    kmax = dep[0];
    if (dep[1] > kmax) kmax = dep[1];
    if (dep[2] > kmax) kmax = dep[2];
  end

endmodule
`default_nettype wire

// ----- design/tds_queue.sv -----
// short queue between the front end and the sorter
// depends on tds_pkg
`default_nettype none
module tds_queue
  import tds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire key_item_t wr_item,
  output logic           space,
  output logic           rd_valid,
  output key_item_t      rd_item,
  input  wire logic      rd_en
);

  localparam int unsigned Depth = 8;
  key_item_t        mem [Depth];
  logic [2:0]       wp, rp;
  logic [3:0]       cnt;

  // four slots kept free for the three front stages plus one
  assign space    = (cnt <= 4'd4);
  assign rd_valid = (cnt != 4'd0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 3'd1;
      if (rd_en && rd_valid) rp <= rp + 3'd1;
      cnt <= cnt + {3'd0, wr_en} - {3'd0, rd_en && rd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_item;
  end

endmodule
`default_nettype wire

// ----- design/tds_sorter.sv -----
// back end: stores keys, then emits them by repeated minimum scans
// depends on tds_pkg
`default_nettype none
module tds_sorter
  import tds_pkg::*;
#(
  parameter int unsigned MaxTris = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire key_item_t q_item,
  output logic           q_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [IdxW-1:0] out_index,
  output logic [KeyW-1:0] out_depth,
  output logic           out_last
);

  localparam int unsigned AW = (MaxTris > 1) ? $clog2(MaxTris) : 1;
  localparam int unsigned CW = $clog2(MaxTris + 1);

  logic signed [KeyW-1:0] keys [MaxTris];
  logic [IdxW-1:0]        ids  [MaxTris];
  logic [MaxTris-1:0]     done, done_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          ptr, ptr_next;
  logic [CW-1:0]          left, left_next;
  logic [AW-1:0]          best, best_next;
  logic                   have, have_next;
  logic signed [KeyW-1:0] bkey, bkey_next;
  logic [IdxW-1:0]        bid, bid_next;
  logic signed [KeyW-1:0] rkey;
  logic [IdxW-1:0]        rid;
  logic [AW-1:0]          rpos;
  logic                   rv;
  srt_state_t             state, state_next;
  logic                   store;

  always_comb begin
    state_next = state;
    case (state)
      SRT_LOAD: if (q_valid && q_item.last) state_next = SRT_NEXT;
      SRT_NEXT: state_next = (left == '0) ? SRT_LOAD : SRT_SCAN;
      SRT_SCAN: if (ptr == count) state_next = SRT_EMIT;
      SRT_EMIT: if (out_ready) state_next = SRT_NEXT;
      default:  state_next = SRT_LOAD;
    endcase
  end

  always_comb begin
    q_take = (state == SRT_LOAD) && q_valid;
    store  = q_take && (count < CW'(MaxTris));
    count_next = count;
    ptr_next = ptr;
    left_next = left;
    best_next = best;
    have_next = have;
    bkey_next = bkey;
    bid_next = bid;
    done_next = done;
    case (state)
      SRT_LOAD: begin
        if (store) count_next = count + CW'(1);
        if (q_take && q_item.last) begin
          left_next = store ? count + CW'(1) : count;
          count_next = left_next;
          done_next = '0;
        end
      end
      SRT_NEXT: begin
        ptr_next = '0;
        have_next = 1'b0;
        if (left == '0) count_next = '0;
      end
      SRT_SCAN: begin
        // strict compare keeps load order among equal keys
        if (rv && !done[rpos] && (!have || rkey < bkey)) begin
          best_next = rpos;
          bkey_next = rkey;
          bid_next = rid;
          have_next = 1'b1;
        end
        if (ptr != count) ptr_next = ptr + CW'(1);
      end
      SRT_EMIT: begin
        if (out_ready) begin
          done_next[best] = 1'b1;
          left_next = left - CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = (state == SRT_EMIT);
  assign out_index = bid;
  assign out_depth = bkey;
  assign out_last  = (left == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SRT_LOAD;
      count <= '0;
      left <= '0;
      ptr <= '0;
      have <= 1'b0;
      done <= '0;
      rv <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      left <= left_next;
      ptr <= ptr_next;
      have <= have_next;
      done <= done_next;
      rv <= (state == SRT_SCAN) && (ptr != count);
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
    bkey <= bkey_next;
    bid <= bid_next;
    rkey <= keys[ptr[AW-1:0]];
    rid <= ids[ptr[AW-1:0]];
    rpos <= ptr[AW-1:0];
    if (store) begin
      keys[count[AW-1:0]] <= q_item.key;
      ids[count[AW-1:0]]  <= q_item.idx;
    end
  end

endmodule
`default_nettype wire

// ----- design/triangle_depth_sort_unit.sv -----
// top level of the triangle depth sort unit with its configuration registers
// depends on tds_pkg, tds_front, tds_queue and tds_sorter
`default_nettype none
// Triangles are taken one per cycle while the queue has room: each passes a
// three-stage key pipeline (products, sums with saturation, maximum) into an
// eight-entry queue. The sorter stores up to MAX_TRIS keys; after the triangle
// marked last it emits them in ascending depth order, one per minimum scan of
// the stored set; meanwhile no new triangle is taken once more than four keys
// wait in the queue.
module triangle_depth_sort_unit
  import tds_pkg::*;
#(
  parameter int unsigned MAX_TRIS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tri_index, ax, ay, az, bx, by_coord, bz, cx, cy, cz, zero pad
  input  wire logic [295:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_index, out_depth, zero pad
  output logic [71:0]      m_tdata,
  output logic             m_tlast
);

  logic signed [CoordW-1:0] coeff_x, coeff_y, coeff_z, offset;
  logic       kv, qspace, qvalid, qtake;
  key_item_t  kitem, qitem;
  logic [IdxW-1:0] oidx;
  logic [KeyW-1:0] odep;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_x <= '0;
      coeff_y <= '0;
      coeff_z <= 32'sd65536;
      offset  <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegCoeffX: coeff_x <= pwdata;
        RegCoeffY: coeff_y <= pwdata;
        RegCoeffZ: coeff_z <= pwdata;
        RegOffset: offset  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCoeffX: prdata = coeff_x;
      RegCoeffY: prdata = coeff_y;
      RegCoeffZ: prdata = coeff_z;
      RegOffset: prdata = offset;
      default:   prdata = '0;
    endcase
  end

  tds_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_idx(s_tdata[IdxW-1:0]), .in_pos(s_tdata[IdxW +: 9*CoordW]),
    .in_last(s_tlast),
    .coeff_x, .coeff_y, .coeff_z, .offset,
    .key_valid(kv), .key_item(kitem), .q_space(qspace)
  );

  tds_queue u_queue (
    .clk, .rst,
    .wr_en(kv && qspace), .wr_item(kitem), .space(qspace),
    .rd_valid(qvalid), .rd_item(qitem), .rd_en(qtake)
  );

  tds_sorter #(.MaxTris(MAX_TRIS)) u_sorter (
    .clk, .rst,
    .q_valid(qvalid), .q_item(qitem), .q_take(qtake),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_index(oidx), .out_depth(odep), .out_last(m_tlast)
  );

  assign m_tdata = {2'b00, odep, oidx};

endmodule
`default_nettype wire

// ----- design/tds_checker.sv -----
// port-level checks for the triangle depth sort unit
// depends on triangle_depth_sort_unit
`default_nettype none
module tds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic        m_tlast
);

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:70] == 2'b00)
    else $error("padding not zero");

endmodule

bind triangle_depth_sort_unit tds_checker u_tds_checker (
  .clk, .rst, .pready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for triangle_depth_sort_unit: loads triangle sets over the slave stream,
// predicts each back-to-front order and checks the master stream; depends on tds_pkg and triangle_depth_sort_unit
module tb_top;
  import tds_pkg::*;

  localparam int unsigned MaxTris   = 64;
  localparam int unsigned CycleCap  = 1500000;
  localparam int unsigned DrainWait = 40;

  typedef struct {
    logic [IdxW-1:0]          idx;
    logic signed [CoordW-1:0] pos [9];
    logic                     last;
  } tri_t;

  typedef struct {
    logic [IdxW-1:0]        idx;
    logic signed [KeyW-1:0] key;
    logic                   last;
  } sorted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // tri_index, ax, ay, az, bx, by_coord, bz, cx, cy, cz, zero pad
  logic [295:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // out_index, out_depth, zero pad
  logic [71:0] m_tdata;
  logic m_tlast;

  logic signed [CoordW-1:0] coeff_x, coeff_y, coeff_z, z_offset;
  logic signed [KeyW-1:0]   held_key [MaxTris];
  logic [IdxW-1:0]          held_idx [MaxTris];
  int unsigned              held_count;
  sorted_t                  order_q[$];
  int unsigned              fail_count;
  int unsigned              sent_count;
  int unsigned              cycle_count;
  bit                       no_idle;

  triangle_depth_sort_unit #(.MAX_TRIS(MaxTris)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [KeyW-1:0] view_depth(logic signed [CoordW-1:0] x,
      logic signed [CoordW-1:0] y, logic signed [CoordW-1:0] z);
    logic signed [127:0] acc;
    logic signed [127:0] term;
    begin
      term = coeff_x * x;
      acc = term;
      term = coeff_y * y;
      acc = acc + term;
      term = coeff_z * z;
      acc = acc + term;
      term = z_offset;
      acc = acc + (term <<< 16);
      if (acc > 128'sh7FFFFFFFFFFFFFFF) return KeyMax;
      if (acc < -128'sh8000000000000000) return KeyMin;
      return acc[KeyW-1:0];
    end
  endfunction

  // store one accepted triangle while fewer than MaxTris are held, and on the last one queue the sorted set
  function automatic void predict_order(tri_t t);
    logic signed [KeyW-1:0] k, d;
    sorted_t s, run[$];
    int j;
    begin
      if (held_count < MaxTris) begin
        k = view_depth(t.pos[0], t.pos[1], t.pos[2]);
        d = view_depth(t.pos[3], t.pos[4], t.pos[5]);
        if (d > k) k = d;
        d = view_depth(t.pos[6], t.pos[7], t.pos[8]);
        if (d > k) k = d;
        held_key[held_count] = k;
        held_idx[held_count] = t.idx;
        held_count++;
      end
      if (t.last) begin
        for (int i = 0; i < held_count; i++) begin
          s.idx = held_idx[i];
          s.key = held_key[i];
          s.last = 1'b0;
          j = run.size();
          while (j > 0 && run[j-1].key > s.key) j--;
          run.insert(j, s);
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[i]) order_q.insert(order_q.size(), run[i]);
        held_count = 0;
      end
    end
  endfunction

  // checker: equal keys are matched by index within the tie run, so any order among them is accepted
  always @(posedge clk) begin
    logic [IdxW-1:0] got_idx;
    logic signed [KeyW-1:0] got_key;
    sorted_t want, tmp;
    if (!rst) m_tready <= no_idle || ($urandom_range(99) >= 30);
    if (!rst && m_tvalid && m_tready) begin
      got_idx = m_tdata[5:0];
      got_key = m_tdata[69:6];
      if (order_q.size() == 0) begin
        $error("transfer with no result pending: out_index %0d", got_idx);
        fail_count++;
      end else begin
        if (order_q[0].key == got_key && order_q[0].idx != got_idx) begin
          for (int i = 1; i < order_q.size() && order_q[i].key == got_key; i++)
            if (order_q[i].idx == got_idx) begin
              tmp = order_q[i];
              order_q[i].idx = order_q[0].idx;
              order_q[0].idx = tmp.idx;
              break;
            end
        end
        want = order_q.pop_front();
        if (got_idx !== want.idx) begin
          $error("out_index expected %0d actual %0d", want.idx, got_idx);
          fail_count++;
        end
        if (got_key !== want.key) begin
          $error("out_depth expected %0d actual %0d", want.key, got_key);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("out_last expected %0d actual %0d", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] reg_id, logic signed [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_id)
      RegCoeffX: coeff_x = value;
      RegCoeffY: coeff_y = value;
      RegCoeffZ: coeff_z = value;
      RegOffset: z_offset = value;
      default: ;
    endcase
  endtask

  task automatic send_tri(tri_t t);
    if (!no_idle && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tdata <= {2'b00, t.pos[8], t.pos[7], t.pos[6], t.pos[5], t.pos[4], t.pos[3],
                t.pos[2], t.pos[1], t.pos[0], t.idx};
    s_tlast <= t.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    predict_order(t);
  endtask

  // drop valid and let the set drain before anything else happens
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4, 5: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t random_tri(logic last);
    tri_t t;
    begin
      t.idx = IdxW'($urandom_range(0, 63));
      foreach (t.pos[i]) t.pos[i] = pick_value();
      t.last = last;
      return t;
    end
  endfunction

  task automatic test_directed_extremes();
    tri_t t;
    t = random_tri(1'b1);
    t.idx = 6'd63;
    send_tri(t);
    wait_drained();
    write_reg(RegCoeffX, 32'sh7FFFFFFF);
    write_reg(RegCoeffY, 32'sh7FFFFFFF);
    write_reg(RegCoeffZ, 32'sh7FFFFFFF);
    write_reg(RegOffset, 32'sh7FFFFFFF);
    // positive and negative saturation, then equal keys with indexes 0 and 63 and with indexes 2 and 3
    t.idx = 6'd0;
    foreach (t.pos[i]) t.pos[i] = 32'sh7FFFFFFF;
    t.last = 1'b0;
    send_tri(t);
    t.idx = 6'd1;
    foreach (t.pos[i]) t.pos[i] = 32'sh80000000;
    send_tri(t);
    t.idx = 6'd63;
    foreach (t.pos[i]) t.pos[i] = 32'sh7FFFFFFF;
    send_tri(t);
    t.idx = 6'd2;
    foreach (t.pos[i]) t.pos[i] = 32'sd0;
    t.pos[8] = 32'sd5;
    send_tri(t);
    t.idx = 6'd3;
    t.pos[8] = 32'sd0;
    t.pos[2] = 32'sd5;
    t.last = 1'b1;
    send_tri(t);
    wait_drained();
    write_reg(RegCoeffX, 32'sh80000000);
    write_reg(RegCoeffY, 32'sh80000000);
    write_reg(RegCoeffZ, 32'sh80000000);
    write_reg(RegOffset, 32'sh80000000);
    for (int i = 0; i < 6; i++) send_tri(random_tri(i == 5));
    wait_drained();
  endtask

  task automatic test_store_full();
    write_reg(RegCoeffX, pick_value());
    write_reg(RegCoeffY, pick_value());
    write_reg(RegCoeffZ, 32'sh00010000);
    write_reg(RegOffset, pick_value());
    // six triangles past a full store are dropped, the last of them closes the set
    for (int i = 0; i < MaxTris + 6; i++) send_tri(random_tri(i == MaxTris + 5));
    wait_drained();
  endtask

  task automatic test_random_sets();
    int unsigned n, sets;
    sets = 0;
    while (sent_count < 280) begin
      no_idle = (sets >= 4 && sets < 8);
      if ($urandom_range(2) == 0) begin
        write_reg(RegCoeffX, pick_value());
        write_reg(RegCoeffY, pick_value());
        write_reg(RegCoeffZ, pick_value());
        write_reg(RegOffset, pick_value());
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_tri(random_tri(i == n - 1));
      wait_drained();
      sets++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    coeff_x = 0;
    coeff_y = 0;
    coeff_z = 32'sh00010000;
    z_offset = 0;
    held_count = 0;
    fail_count = 0;
    sent_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_store_full();
    test_random_sets();
    if (order_q.size() != 0) begin
      $error("%0d results never arrived", order_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
design/tds_pkg.sv
design/tds_front.sv
design/tds_queue.sv
design/tds_sorter.sv
design/triangle_depth_sort_unit.sv
design/tds_checker.sv
tb/sv/tb_top.sv
